// ----- rtl/stg_pkg.sv -----
// ----------------------------------------------------------------------------
// stg_pkg: shared types and constants of the sine tone generator
// Register indexes, reset values and the tick descriptor passed to the emitter.
// ----------------------------------------------------------------------------
package stg_pkg;

  // results per tick never exceed this, whatever the channel count
  localparam int RESULT_LIMIT = 8;

  localparam logic [31:0] PHASE_STEP_RESET    = 32'd42852281;
  localparam logic [3:0]  CHANNEL_COUNT_RESET = 4'd2;

  localparam int MAG_BITS    = 15;
  localparam int SAMPLE_BITS = 16;
  localparam int INDEX_BITS  = 3;

  typedef enum logic {
    REG_PHASE_STEP    = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } reg_index_t;

  // one accepted tick waiting for the copy emitter
  typedef struct packed {
    logic       neg;     // lower half of the wave: negate the magnitude
    logic [3:0] copies;  // words to emit, 0 to RESULT_LIMIT
  } tick_t;

endpackage

// ----- rtl/stg_sine_rom.sv -----
// ----------------------------------------------------------------------------
// stg_sine_rom: quarter-wave sine magnitude table
// Synchronous ROM of 2^ADDR_BITS + 1 entries, amplitude 32767, filled at
// start-up from a fixed-point Taylor series; the read data is registered.
// ----------------------------------------------------------------------------
module stg_sine_rom #(
  parameter int ADDR_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [ADDR_BITS:0]           rd_addr,
  output logic [stg_pkg::MAG_BITS-1:0] rd_data
);

  localparam int unsigned NFull = 32'd1 << ADDR_BITS;
  localparam int unsigned Depth = NFull + 32'd1;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1073741824;
  localparam logic [63:0] MagFull   = 64'd32767;

  logic [stg_pkg::MAG_BITS-1:0] rom [0:Depth-1];

  // (term * x * x) in Q30, truncated at each product
  function automatic logic [63:0] cube_step(input logic [63:0] term, input logic [63:0] x);
    logic [63:0] p;
    p = (term * x) >> 30;
    return (p * x) >> 30;
  endfunction

  function automatic logic [stg_pkg::MAG_BITS-1:0] quarter_mag(input int unsigned k);
    logic        [63:0] x;
    logic        [63:0] term;
    logic signed [63:0] s;
    logic        [63:0] u;
    if (k == 0) return '0;
    if (k >= NFull) return stg_pkg::MAG_BITS'(MagFull);
    x    = (64'(k) * HalfPiQ30) >> ADDR_BITS;
    s    = signed'(x);
    term = cube_step(x, x) / 64'd6;    s = s - signed'(term);
    term = cube_step(term, x) / 64'd20;  s = s + signed'(term);
    term = cube_step(term, x) / 64'd42;  s = s - signed'(term);
    term = cube_step(term, x) / 64'd72;  s = s + signed'(term);
    term = cube_step(term, x) / 64'd110; s = s - signed'(term);
    term = cube_step(term, x) / 64'd156; s = s + signed'(term);
    term = cube_step(term, x) / 64'd210; s = s - signed'(term);
    term = cube_step(term, x) / 64'd272; s = s + signed'(term);
    if (s < 0) s = '0;
    if (s > signed'(OneQ30)) s = signed'(OneQ30);
    u = unsigned'(s);
    return stg_pkg::MAG_BITS'((u * MagFull) >> 30);
  endfunction

  // fill the table once; it is never written in operation
  initial begin
    for (int unsigned k = 0; k < Depth; k++) begin
      rom[k] = quarter_mag(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rom[rd_addr];
    end
  end

endmodule

// ----- rtl/stg_copy_emitter.sv -----
// ----------------------------------------------------------------------------
// stg_copy_emitter: per-channel copy output stage
// Takes one tick and its table magnitude, applies the sign and emits one
// word per channel copy from an output register, marking the final copy.
// ----------------------------------------------------------------------------
module stg_copy_emitter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         tick_valid,
  input  stg_pkg::tick_t               tick,
  input  logic [stg_pkg::MAG_BITS-1:0] mag,
  output logic                         tick_take,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,  // sample[15:0], channel_index[18:16], zero
  output logic                         m_tlast   // last_copy
);

  logic [stg_pkg::SAMPLE_BITS-1:0] sample;
  logic [stg_pkg::INDEX_BITS-1:0]  idx;
  logic [3:0]                      copies;
  logic                            last;
  logic                            can_load;
  logic                            load;

  assign last      = ({1'b0, idx} + 4'd1) == copies;
  assign can_load  = !m_tvalid || (m_tready && last);
  // a tick with no room is consumed at once and emits nothing
  assign tick_take = tick_valid && ((tick.copies == 4'd0) || can_load);
  assign load      = tick_valid && (tick.copies != 4'd0) && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      priority if (load) begin
        m_tvalid <= 1'b1;
        idx      <= '0;
      end else if (m_tvalid && m_tready) begin
        if (last) begin
          m_tvalid <= 1'b0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      copies <= tick.copies;
      sample <= tick.neg ? 16'd0 - {1'b0, mag} : {1'b0, mag};
    end
  end

  assign m_tdata = {5'd0, idx, sample};
  assign m_tlast = last;

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (copies != 4'd0) && (({1'b0, idx}) < copies))
    else $error("channel index beyond copy count");

  a_idx_advance: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !last) |=> m_tvalid && (idx == 3'($past(idx) + 3'd1)))
    else $error("channel index did not advance after a taken word");

  a_load_first: assert property (@(posedge clk) disable iff (rst)
    load |=> m_tvalid && (idx == 3'd0))
    else $error("new tick did not start at channel zero");
`endif

endmodule

// ----- rtl/sine_tone_generator_unit.sv -----
// ----------------------------------------------------------------------------
// sine_tone_generator_unit: DDS sine tone source
// Each input word on s_* is one sample tick carrying the free room of the sink
// (s_tdata[3:0]). The tick's sample is read from a quarter-wave ROM at the
// current phase, the 32-bit phase then advances by phase_step. The sample is
// emitted on m_* once per channel, up to the free room, channel order, with
// m_tlast on the final copy; a tick with no room emits nothing.
// Path: an accepted tick passes the tick and ROM read registers, then the
// output register. Throughput: one word per cycle on m_* while m_tready is
// high; the next tick is accepted and its ROM read done while copies still
// drain.
// When m_tready is low the output word holds and the tick stage fills, then
// s_tready drops. Reset clears the phase, sets phase_step to 42852281 and
// channel_count to 2, and empties both stages; no clearing pass is needed.
// Configuration: cfg_we with cfg_addr 0 (phase_step) or 1 (channel_count),
// written only while the block is idle: a rule for the user, not enforced by the block.
// ----------------------------------------------------------------------------
module sine_tone_generator_unit #(
  parameter int TABLE_ADDR_BITS = 10,
  parameter int MAX_CHANNELS    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // free_slots[3:0], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // sample[15:0], channel_index[18:16], zero
  output logic        m_tlast    // last_copy
);

  localparam int ChCap = (MAX_CHANNELS < stg_pkg::RESULT_LIMIT) ?
                         MAX_CHANNELS : stg_pkg::RESULT_LIMIT;
  localparam logic [3:0] ChCapW = 4'(ChCap);
  localparam logic [TABLE_ADDR_BITS:0] NFull = (TABLE_ADDR_BITS+1)'(1) << TABLE_ADDR_BITS;

  logic [31:0]          phase_step;
  logic [3:0]           channel_count;
  logic [31:0]          phase;
  logic                 tick_valid;
  stg_pkg::tick_t       tick;
  logic                 tick_take;
  logic                 accept;
  logic [3:0]           free_slots;
  logic [3:0]           ch_eff;
  logic [3:0]           copies;
  logic [TABLE_ADDR_BITS-1:0] tab_idx;
  logic [TABLE_ADDR_BITS:0]   rom_addr;
  logic [stg_pkg::MAG_BITS-1:0] mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= stg_pkg::PHASE_STEP_RESET;
      channel_count <= stg_pkg::CHANNEL_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (stg_pkg::reg_index_t'(cfg_addr))
        stg_pkg::REG_PHASE_STEP:    phase_step    <= cfg_wdata;
        stg_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_wdata[3:0];
      endcase
    end
  end

  assign free_slots = s_tdata[3:0];
  assign s_tready   = !tick_valid || tick_take;
  assign accept     = s_tvalid && s_tready;

  always_comb begin
    priority if (channel_count == 4'd0) begin
      ch_eff = 4'd1;
    end else if (channel_count > ChCapW) begin
      ch_eff = ChCapW;
    end else begin
      ch_eff = channel_count;
    end
    copies = (free_slots < ch_eff) ? free_slots : ch_eff;
  end

  // odd quadrants read the table mirrored
  assign tab_idx  = phase[29 -: TABLE_ADDR_BITS];
  assign rom_addr = phase[30] ? NFull - {1'b0, tab_idx} : {1'b0, tab_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      tick_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase + phase_step;
        tick_valid <= 1'b1;
      end else if (tick_take) begin
        tick_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick.neg    <= phase[31];
      tick.copies <= copies;
    end
  end

  stg_sine_rom #(
    .ADDR_BITS (TABLE_ADDR_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rom_addr),
    .rd_data (mag)
  );

  stg_copy_emitter u_emit (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick       (tick),
    .mag        (mag),
    .tick_take  (tick_take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the sine tone generator unit
// Streams sample ticks with random room, predicts the sine copies of each tick
// from a bit-exact Taylor-series quarter wave and a private phase accumulator,
// and checks every output word in order while both sides idle and stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_BITS   = 10;
  localparam int TABLE_SIZE   = 1 << TABLE_BITS;
  localparam int CHANNEL_MAX  = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  typedef struct packed {
    logic [stg_pkg::SAMPLE_BITS-1:0] sample;
    logic [stg_pkg::INDEX_BITS-1:0]  channel;
    logic                            last;
  } copy_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = stg_pkg::REG_PHASE_STEP;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // free_slots[3:0], zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // sample[15:0], channel_index[18:16], zero
  logic        m_tlast;          // last_copy

  // stimulus and expectations
  logic [3:0]  tick_queue[$];
  copy_t       pending_copies[$];
  int          ticks_pushed = 0;
  int          ticks_accepted = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // handshake bookkeeping; the accept and take flags update at the rising edge
  bit          tick_accepted = 1'b0;
  bit          word_taken = 1'b0;
  bit          send_idle = 1'b0;
  bit          sink_idle = 1'b0;
  int          send_wait = 0;
  int          sink_wait = 0;
  int          sink_hold = 0;

  // predictor state
  logic [31:0] tone_step = stg_pkg::PHASE_STEP_RESET;
  logic [3:0]  tone_channels = stg_pkg::CHANNEL_COUNT_RESET;
  logic [31:0] tone_phase = '0;

  sine_tone_generator_unit #(
    .TABLE_ADDR_BITS(TABLE_BITS),
    .MAX_CHANNELS   (CHANNEL_MAX)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Quarter-wave magnitude at table point k, Q30 Taylor sine scaled to 32767
  function automatic logic [stg_pkg::SAMPLE_BITS-1:0] quarter_level(input int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint unsigned level;
    longint          s;
    int unsigned     n;
    if (k == 0) return '0;
    if (k >= TABLE_SIZE) return 16'd32767;
    x = (longint'(k) * HALF_PI_Q30) >> TABLE_BITS;
    term = x;
    s = $signed(x);
    for (n = 1; n <= 8; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n[0]) s = s - $signed(term);
      else s = s + $signed(term);
    end
    if (s < 0) s = 0;
    if (s > $signed(ONE_Q30)) s = $signed(ONE_Q30);
    level = ($unsigned(s) * 64'd32767) >> 30;
    return 16'(level);
  endfunction

  // Fold the phase onto the quarter wave; the lower half negates
  function automatic logic [stg_pkg::SAMPLE_BITS-1:0] sine_at(input logic [31:0] phase);
    logic [TABLE_BITS-1:0]           idx;
    logic [stg_pkg::SAMPLE_BITS-1:0] mag;
    idx = phase[29 -: TABLE_BITS];
    if (phase[30]) mag = quarter_level(TABLE_SIZE - idx);
    else mag = quarter_level(idx);
    return phase[31] ? -mag : mag;
  endfunction

  // Sender: hold each word until taken, then wait a drawn gap if send_idle is set
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || tick_accepted)) begin
      if (send_wait > 0) begin
        send_wait--;
        s_tvalid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        s_tdata  <= {4'b0000, tick_queue.pop_front()};
        s_tvalid <= 1'b1;
        send_wait = send_idle ? $urandom_range(0, 12) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a long hold-off when asked, else a drawn stall after each word if sink_idle is set
  always @(negedge clk) begin
    if (word_taken) sink_wait = sink_idle ? $urandom_range(0, 12) : 0;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      m_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor and predictor
  always @(posedge clk) begin : monitor
    copy_t                           want;
    logic [stg_pkg::SAMPLE_BITS-1:0] tone;
    int unsigned                     chans;
    int unsigned                     copies;
    int unsigned                     room;
    tick_accepted = !rst && s_tvalid && s_tready;
    word_taken    = !rst && m_tvalid && m_tready;
    if (rst) begin
      tone_step     = stg_pkg::PHASE_STEP_RESET;
      tone_channels = stg_pkg::CHANNEL_COUNT_RESET;
      tone_phase    = '0;
    end else if (cfg_we) begin
      if (cfg_addr == stg_pkg::REG_PHASE_STEP) tone_step = cfg_wdata;
      else tone_channels = cfg_wdata[3:0];
    end
    if (word_taken) begin
      if (pending_copies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected word: sample %0d channel %0d last %0b",
                   $signed(m_tdata[15:0]), m_tdata[18:16], m_tlast);
      end else begin
        want = pending_copies.pop_front();
        if (m_tdata[15:0] !== want.sample || m_tdata[18:16] !== want.channel ||
            m_tlast !== want.last || m_tdata[23:19] !== 5'd0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display({"copy mismatch: expected sample %0d channel %0d last %0b,",
                      " got %0d %0d %0b pad %h"},
                     $signed(want.sample), want.channel, want.last,
                     $signed(m_tdata[15:0]), m_tdata[18:16], m_tlast, m_tdata[23:19]);
        end
      end
    end
    if (tick_accepted) begin
      ticks_accepted++;
      tone  = sine_at(tone_phase);
      room  = s_tdata[3:0];
      chans = (tone_channels == 0) ? 1 : tone_channels;
      if (chans > CHANNEL_MAX) chans = CHANNEL_MAX;
      if (chans > stg_pkg::RESULT_LIMIT) chans = stg_pkg::RESULT_LIMIT;
      copies = (room < chans) ? room : chans;
      for (int unsigned k = 0; k < copies; k++)
        pending_copies.push_back('{tone, k[stg_pkg::INDEX_BITS-1:0], k + 1 == copies});
      tone_phase = tone_phase + tone_step;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("simulation failed");
    $finish;
  end

  task automatic push_tick(input logic [3:0] room);
    tick_queue.push_back(room);
    ticks_pushed++;
  endtask

  // Let every tick through and every copy out, then allow for empty ticks
  task automatic wait_drained();
    while (ticks_accepted != ticks_pushed || pending_copies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input stg_pkg::reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Retune while idle; junk above the channel field must be ignored
  task automatic set_tone(input logic [31:0] step, input logic [3:0] chans);
    wait_drained();
    write_reg(stg_pkg::REG_PHASE_STEP, step);
    write_reg(stg_pkg::REG_CHANNEL_COUNT, ($urandom() & 32'hFFFF_FFF0) | chans);
  endtask

  function automatic logic [3:0] random_room();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  initial begin : stimulus
    logic [31:0] step;
    logic [3:0]  chans;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset tuning: no room, partial room, room beyond the channel count
    push_tick(4'd0);
    push_tick(4'd1);
    push_tick(4'd2);
    push_tick(4'd15);
    push_tick(4'd9);
    push_tick(4'd3);

    // quarter-turn steps land exactly on every quadrant boundary
    set_tone(32'h4000_0000, 4'd8);
    repeat (5) push_tick(4'd8);

    // a zero channel count behaves as one channel
    set_tone(32'hFFFF_FFFF, 4'd0);
    push_tick(4'd1);
    push_tick(4'd4);
    push_tick(4'd0);

    // channel count above the limit saturates at eight
    set_tone(32'h8000_0000, 4'd15);
    push_tick(4'd15);
    push_tick(4'd7);
    push_tick(4'd8);

    set_tone(32'h0000_0000, 4'd1);
    push_tick(4'd5);
    push_tick(4'd1);

    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 3))
        0:       step = $urandom_range(1, 32'h0040_0000);
        1:       step = 32'hFFFF_FFFF - $urandom_range(0, 32'h0040_0000);
        default: step = $urandom();
      endcase
      if ($urandom_range(0, 4) == 0) chans = 4'($urandom_range(0, 15));
      else chans = 4'($urandom_range(1, 8));
      if (p == 2) chans = 4'd8;
      set_tone(step, chans);
      @(posedge clk);
      send_idle = p[0];
      sink_idle = p[1];
      if (p == 2) begin
        // sink stalls for long while ticks keep coming: the block must back up
        sink_hold = 400;
        repeat (30) push_tick(4'd8);
      end else if (p == 4) begin
        repeat (15) push_tick(random_room());
        wait_drained();
        repeat (15) push_tick(random_room());
      end else begin
        repeat (30) push_tick(random_room());
      end
    end

    wait_drained();
    if (mismatch_count == 0 && pending_copies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
